### sv/assert_macros.svh
// Assertion macros used by pti_checker.sv.
// Depends on nothing; include once per file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### sv/pti_pkg.sv
// Types and codes for the prefix tree insert/lookup block.
// Depends on nothing.
package pti_pkg;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_STEP
   } state_type;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_PREFIX = 2'd2;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_OVERFLOW = 1'b1;

endpackage

### sv/pti_link_mem.sv
// Child link memory: one entry per (node, letter), holding {end mark, child}.
// Single write port, single registered read port. Depends on nothing.
module pti_link_mem #(
   parameter int DEPTH = 26624,
   parameter int AW    = 15,
   parameter int DW    = 11
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/prefix_tree_insert_lookup.sv
// Channel | dir | word                                          | result
// req_    | in  | operation, letter, has_letter, last_letter    | one per letter
// rsp_    | out | found, status                                 | one per last_letter word
// Each input word goes through the child link read, then the update and write-back.
// The cursor carries from one read to the next, so no new word is taken until the last one is written back.
// A final word holds in ST_STEP while the result register is still full.
// After reset the link memory is swept to zero, all NODE_COUNT*ALPHABET_SIZE entries
// (26624 at the defaults), with req_ready low throughout.
module prefix_tree_insert_lookup import pti_pkg::*; #(
   parameter int NODE_COUNT    = 1024,
   parameter int ALPHABET_SIZE = 26
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_operation,
   input  logic [4:0] req_letter,
   input  logic       req_has_letter,
   input  logic       req_last_letter,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_found,
   output logic       rsp_status
);

   localparam int DEPTH = NODE_COUNT * ALPHABET_SIZE;
   localparam int NW    = $clog2(NODE_COUNT);
   localparam int UW    = NW + 1;
   localparam int SW    = $clog2(DEPTH);
   localparam int DW    = NW + 1;

   state_type      state_ff, state_in;
   logic [SW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [NW-1:0]  cursor_ff, cursor_in;
   logic           cur_root_ff, cur_root_in;
   logic           cur_end_ff, cur_end_in;
   logic           root_end_ff, root_end_in;
   logic           walk_failed_ff, walk_failed_in;
   logic           overflow_ff, overflow_in;
   logic [UW-1:0]  nodes_used_ff, nodes_used_in;
   logic [1:0]     op_ff, op_in;
   logic           last_ff, last_in;
   logic           issued_ff, issued_in;
   logic [SW-1:0]  slot_ff, slot_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_found_ff, rsp_found_in;
   logic           rsp_status_ff, rsp_status_in;

   logic           rd_en;
   logic [DW-1:0]  rd_data;
   logic           wr_en;
   logic [SW-1:0]  wr_addr;
   logic [DW-1:0]  wr_data;

   logic [SW-1:0]  slot_calc;
   logic           letter_ok;
   logic           step;
   logic           stall;
   logic           alloc;
   logic           ok;
   logic           end_now;
   logic           mark;
   logic [NW-1:0]  n_cursor;
   logic           n_root;
   logic           n_end;
   logic           n_fail;
   logic           n_ovf;
   logic [UW-1:0]  n_used;

   assign slot_calc = SW'(SW'(cursor_ff) * SW'(ALPHABET_SIZE)) + SW'(req_letter);
   assign letter_ok = {4'd0, req_letter} < 9'(ALPHABET_SIZE);

   pti_link_mem #(
      .DEPTH (DEPTH),
      .AW    (SW),
      .DW    (DW)
   ) u_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (slot_calc),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_cnt_ff     <= '0;
         cursor_ff      <= '0;
         cur_root_ff    <= 1'b1;
         cur_end_ff     <= 1'b0;
         root_end_ff    <= 1'b0;
         walk_failed_ff <= 1'b0;
         overflow_ff    <= 1'b0;
         nodes_used_ff  <= UW'(1);
         issued_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_cnt_ff     <= clr_cnt_in;
         cursor_ff      <= cursor_in;
         cur_root_ff    <= cur_root_in;
         cur_end_ff     <= cur_end_in;
         root_end_ff    <= root_end_in;
         walk_failed_ff <= walk_failed_in;
         overflow_ff    <= overflow_in;
         nodes_used_ff  <= nodes_used_in;
         issued_ff      <= issued_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      last_ff       <= last_in;
      slot_ff       <= slot_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in       = state_ff;
      clr_cnt_in     = clr_cnt_ff;
      cursor_in      = cursor_ff;
      cur_root_in    = cur_root_ff;
      cur_end_in     = cur_end_ff;
      root_end_in    = root_end_ff;
      walk_failed_in = walk_failed_ff;
      overflow_in    = overflow_ff;
      nodes_used_in  = nodes_used_ff;
      op_in          = op_ff;
      last_in        = last_ff;
      issued_in      = issued_ff;
      slot_in        = slot_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_found_in   = rsp_found_ff;
      rsp_status_in  = rsp_status_ff;
      req_ready      = 1'b0;
      rd_en          = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = slot_ff;
      wr_data        = '0;

      step     = req_has_letter && (req_operation <= OP_PREFIX)
                 && !walk_failed_ff && !overflow_ff;
      stall    = last_ff && rsp_valid_ff && !rsp_ready;
      alloc    = 1'b0;
      n_cursor = cursor_ff;
      n_root   = cur_root_ff;
      n_end    = cur_end_ff;
      n_fail   = walk_failed_ff;
      n_ovf    = overflow_ff;
      n_used   = nodes_used_ff;

      if (issued_ff) begin
         if (rd_data[NW-1:0] != '0) begin
            n_cursor = rd_data[NW-1:0];
            n_root   = 1'b0;
            n_end    = rd_data[NW];
         end else if (op_ff != OP_INSERT) begin
            n_fail = 1'b1;
         end else if (nodes_used_ff >= UW'(NODE_COUNT)) begin
            n_ovf = 1'b1;
         end else begin
            alloc    = 1'b1;
            n_cursor = nodes_used_ff[NW-1:0];
            n_root   = 1'b0;
            n_end    = 1'b0;
            n_used   = nodes_used_ff + UW'(1);
         end
      end

      ok      = !n_fail && !n_ovf;
      end_now = n_root ? root_end_ff : n_end;
      mark    = last_ff && (op_ff == OP_INSERT) && ok;

      case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + SW'(1);
            if (clr_cnt_ff == SW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = req_operation;
               last_in   = req_last_letter;
               issued_in = step && letter_ok;
               rd_en     = step && letter_ok;
               // keep the link slot of the cursor node for a later new child link or end mark
               if (step && letter_ok) begin
                  slot_in = slot_calc;
               end
               if (step && !letter_ok) begin
                  walk_failed_in = 1'b1;
               end
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (!stall) begin
               wr_en         = alloc || (mark && !n_root);
               wr_data       = {mark, n_cursor};
               cursor_in     = n_cursor;
               cur_root_in   = n_root;
               cur_end_in    = n_end;
               walk_failed_in = n_fail;
               overflow_in   = n_ovf;
               nodes_used_in = n_used;
               issued_in     = 1'b0;
               if (mark && n_root) begin
                  root_end_in = 1'b1;
               end
               if (last_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = n_ovf ? STATUS_OVERFLOW : STATUS_OK;
                  case (op_ff)
                     OP_INSERT: rsp_found_in = ok;
                     OP_SEARCH: rsp_found_in = ok && end_now;
                     OP_PREFIX: rsp_found_in = ok;
                     default:   rsp_found_in = 1'b0;
                  endcase
                  cursor_in      = '0;
                  cur_root_in    = 1'b1;
                  cur_end_in     = 1'b0;
                  walk_failed_in = 1'b0;
                  overflow_in    = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_status = rsp_status_ff;

endmodule

### sv/pti_checker.sv
// Port-level checks for prefix_tree_insert_lookup, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module pti_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_found,
   input logic       rsp_status
);

   // overflow never reports a hit
   `ASSERT_IMPLIES(a_ovf_not_found, clock, reset, rsp_valid && rsp_status, !rsp_found)
   // clearing sweep follows reset
   `ASSERT_NEXT(a_clear_after_reset, clock, 1'b0, reset, !req_ready)
   // req_ready drops after an accepted word
   `ASSERT_NEXT(a_two_cycle_step, clock, reset, req_valid && req_ready, !req_ready)
   // stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_found) && $stable(rsp_status))

endmodule

bind prefix_tree_insert_lookup pti_checker u_pti_checker (.*);

### dv/prefix_tree_insert_lookup_tb.sv
// Self-checking bench for prefix_tree_insert_lookup: letter words in, found/status words out.
// Holds its own trie predictor; directed, random, back-pressure and pool exhaustion phases.
// Depends on pti_pkg and the prefix_tree_insert_lookup RTL.
module prefix_tree_insert_lookup_tb import pti_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODE_COUNT    = 1024;
   localparam int ALPHABET_SIZE = 26;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int LONG_HOLD     = 300;
   localparam int MAX_LETTERS   = 12;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic found;
      logic status;
   } lookup_result_type;

   typedef struct packed {
      logic [3:0]                  len;
      logic [MAX_LETTERS-1:0][4:0] ltrs;
   } letter_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_operation = OP_INSERT;
   logic [4:0] req_letter = '0;
   logic       req_has_letter = 1'b0;
   logic       req_last_letter = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_found;
   logic       rsp_status;

   // predictor state
   int unsigned       child_of [NODE_COUNT*ALPHABET_SIZE];
   bit                word_end [NODE_COUNT];
   int unsigned       walk_node = 0;
   bit                walk_broken = 1'b0;
   bit                pool_ran_out = 1'b0;
   int unsigned       nodes_taken = 1;
   lookup_result_type pending_lookups[$];

   letter_word_type known_words[$];
   int           items_sent = 0;
   int           mismatch_count = 0;
   int           cycle_count = 0;
   bit           req_idle_on = 1'b1;
   bit           rsp_idle_on = 1'b1;
   bit           hold_request = 1'b0;

   prefix_tree_insert_lookup dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_letter     (req_letter),
      .req_has_letter (req_has_letter),
      .req_last_letter(req_last_letter),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_status     (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   function void trie_apply_letter(input logic [1:0] op, input logic [4:0] ltr,
                                   input logic has, input logic last);
      int unsigned       slot;
      int unsigned       child;
      bit                ok;
      lookup_result_type res;
      if (has && op <= OP_PREFIX && !walk_broken && !pool_ran_out) begin
         if (ltr >= ALPHABET_SIZE || walk_node >= NODE_COUNT) begin
            walk_broken = 1'b1;
         end else begin
            slot  = walk_node * ALPHABET_SIZE + ltr;
            child = child_of[slot];
            if (child == 0) begin
               if (op != OP_INSERT) begin
                  walk_broken = 1'b1;
               end else if (nodes_taken >= NODE_COUNT) begin
                  pool_ran_out = 1'b1;
               end else begin
                  child          = nodes_taken;
                  child_of[slot] = child;
                  word_end[child] = 1'b0;
                  nodes_taken++;
               end
            end
            if (!walk_broken && !pool_ran_out)
               walk_node = child;
         end
      end
      if (last) begin
         ok = !walk_broken && !pool_ran_out && walk_node < NODE_COUNT;
         res.found = 1'b0;
         case (op)
            OP_INSERT: begin
               if (ok) begin
                  word_end[walk_node] = 1'b1;
                  res.found = 1'b1;
               end
            end
            OP_SEARCH: res.found = ok && word_end[walk_node];
            OP_PREFIX: res.found = ok;
            default:   res.found = 1'b0;
         endcase
         res.status = pool_ran_out ? STATUS_OVERFLOW : STATUS_OK;
         pending_lookups.push_back(res);
         walk_node    = 0;
         walk_broken  = 1'b0;
         pool_ran_out = 1'b0;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_lookups.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: found %0b status %0b",
                                      rsp_found, rsp_status));
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_found !== want.found)
               report_mismatch($sformatf("found got %0b want %0b", rsp_found, want.found));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status got %0b want %0b", rsp_status, want.status));
         end
      end
   end

   // receiver: random stall bursts, plus one long hold on request
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = LONG_HOLD;
         end else if (stall_left == 0 && rsp_idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 17);
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_letter(input logic [1:0] op, input logic [4:0] ltr,
                              input logic has, input logic last);
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_letter      <= ltr;
      req_has_letter  <= has;
      req_last_letter <= last;
      do @(posedge clock); while (!req_ready);
      trie_apply_letter(op, ltr, has, last);
      items_sent++;
   endtask

   task automatic sender_pause();
      if (req_idle_on && $urandom_range(0, 6) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // noisy words get stray ops, blank items and out-of-range letters
   task automatic send_word(input letter_word_type w, input logic [1:0] op, input bit noisy);
      logic [1:0] step_op;
      for (int i = 0; i < w.len; i++) begin
         if (noisy && $urandom_range(0, 4) == 0) begin
            send_letter(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)), 1'b0, 1'b0);
            sender_pause();
         end
         step_op = (noisy && $urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : op;
         send_letter(step_op, w.ltrs[i], 1'b1, i == w.len - 1);
         sender_pause();
      end
      if (w.len == 0) begin
         send_letter(op, 5'($urandom_range(0, 31)), 1'b0, 1'b1);
         sender_pause();
      end
   endtask

   function automatic letter_word_type make_word(input int max_len, input int hi_letter);
      letter_word_type w;
      w.len = 4'($urandom_range(1, max_len));
      for (int i = 0; i < MAX_LETTERS; i++)
         w.ltrs[i] = 5'($urandom_range(0, hi_letter));
      return w;
   endfunction

   function void remember_word(input letter_word_type w);
      known_words.push_back(w);
      if (known_words.size() > 200)
         void'(known_words.pop_front());
   endfunction

   task automatic test_directed();
      send_letter(OP_SEARCH, 5'd0, 1'b1, 1'b1);        // empty tree
      send_letter(OP_PREFIX, 5'd7, 1'b0, 1'b1);        // empty word prefix
      send_letter(OP_SEARCH, 5'd3, 1'b0, 1'b1);        // root not yet marked
      send_letter(OP_INSERT, 5'd31, 1'b0, 1'b1);       // mark root
      send_letter(OP_SEARCH, 5'd0, 1'b0, 1'b1);
      send_letter(OP_INSERT, 5'd0, 1'b1, 1'b0);        // "ab"
      send_letter(OP_INSERT, 5'd1, 1'b1, 1'b1);
      send_letter(OP_SEARCH, 5'd0, 1'b1, 1'b0);
      send_letter(OP_SEARCH, 5'd1, 1'b1, 1'b1);
      send_letter(OP_SEARCH, 5'd0, 1'b1, 1'b1);        // "a" is only a prefix
      send_letter(OP_PREFIX, 5'd0, 1'b1, 1'b1);
      send_letter(OP_INSERT, 5'd31, 1'b1, 1'b1);       // bad letters
      send_letter(OP_PREFIX, 5'd26, 1'b1, 1'b1);
      send_letter(OP_INSERT, 5'd25, 1'b1, 1'b1);       // "z"
      send_letter(OP_SEARCH, 5'd25, 1'b1, 1'b1);
      send_letter(OP_UNUSED, 5'd0, 1'b1, 1'b1);
      send_letter(OP_INSERT, 5'd2, 1'b1, 1'b0);        // op changes mid-word
      send_letter(OP_SEARCH, 5'd3, 1'b1, 1'b1);
      send_letter(OP_SEARCH, 5'd9, 1'b0, 1'b0);        // blank mid-word
      send_letter(OP_SEARCH, 5'd0, 1'b1, 1'b0);
      send_letter(OP_SEARCH, 5'd1, 1'b1, 1'b1);
   endtask

   task automatic test_random_mix(input int item_goal, input bit allow_idle);
      letter_word_type w;
      int           pick;
      int           stop_at;
      stop_at = items_sent + item_goal;
      if (!allow_idle) begin
         req_idle_on = 1'b0;
         rsp_idle_on = 1'b0;
      end
      while (items_sent < stop_at) begin
         if (allow_idle && $urandom_range(0, 29) == 0)
            req_idle_on = $urandom_range(0, 1);
         if (allow_idle && $urandom_range(0, 29) == 0)
            rsp_idle_on = $urandom_range(0, 1);
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            w = make_word(6, ($urandom_range(0, 3) == 0) ? 25 : 3);
            send_word(w, OP_INSERT, 1'b0);
            remember_word(w);
         end else if (pick < 60 && known_words.size() > 0) begin
            w = known_words[$urandom_range(0, known_words.size() - 1)];
            send_word(w, OP_SEARCH, 1'b0);
         end else if (pick < 75 && known_words.size() > 0) begin
            w = known_words[$urandom_range(0, known_words.size() - 1)];
            w.len = 4'($urandom_range(1, w.len));
            send_word(w, $urandom_range(0, 1) ? OP_PREFIX : OP_SEARCH, 1'b0);
         end else if (pick < 85) begin
            w = make_word(6, 3);
            send_word(w, $urandom_range(0, 1) ? OP_PREFIX : OP_SEARCH, 1'b0);
         end else if (pick < 95) begin
            w = make_word(8, 31);
            send_word(w, 2'($urandom_range(0, 3)), 1'b1);
         end else begin
            w = make_word(1, 31);
            w.len = '0;
            send_word(w, 2'($urandom_range(0, 3)), 1'b0);
         end
      end
   endtask

   task automatic test_backpressure();
      letter_word_type w;
      req_idle_on  = 1'b0;
      hold_request = 1'b1;
      repeat (40) begin
         w = make_word(2, 3);
         send_word(w, 2'($urandom_range(0, 2)), 1'b0);
      end
      req_idle_on = 1'b1;
      wait_drained();
   endtask

   task automatic test_pool_exhaustion();
      letter_word_type w;
      while (nodes_taken < NODE_COUNT) begin
         w = make_word(MAX_LETTERS, 25);
         w.len = MAX_LETTERS;
         send_word(w, OP_INSERT, 1'b0);
         remember_word(w);
      end
      repeat (4) begin
         w = make_word(MAX_LETTERS, 25);
         send_word(w, OP_INSERT, 1'b0);
      end
      // nodes made before the pool ran dry stay reachable
      send_word(w, OP_PREFIX, 1'b0);
      w.len = 4'($urandom_range(1, w.len));
      send_word(w, OP_PREFIX, 1'b0);
      send_word(w, OP_INSERT, 1'b0);
   endtask

   task automatic test_after_overflow();
      test_random_mix(60, 1'b1);
      test_random_mix(40, 1'b0);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      wait_drained();
      test_random_mix(100, 1'b1);
      wait_drained();
      test_backpressure();
      test_pool_exhaustion();
      wait_drained();
      test_after_overflow();
      wait_drained();
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
